// ===== rtl/lfs_pkg.sv =====
package lfs_pkg;

  localparam int OP_W       = 3;
  localparam int TICK_W     = 16;
  localparam int RCOUNT_W   = 8;
  localparam int LED_W      = 8;
  localparam int COLOUR_W   = 4;
  localparam int BURST_W    = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int DEF_MAX_LEDS     = 255;
  localparam int DEF_COLOUR_COUNT = 9;

  localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};
  localparam logic [LED_W-1:0]  LED_MAX  = {LED_W{1'b1}};

  // Command codes; the two remaining codes are ignored.
  typedef enum logic [OP_W-1:0] {
    OP_TICK        = 3'd0,
    OP_TURN_ON     = 3'd1,
    OP_TURN_OFF    = 3'd2,
    OP_NEXT_COLOUR = 3'd3,
    OP_CLEAR       = 3'd4,
    OP_FLASH       = 3'd5
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ON_STEP_TICKS    = 3'd0,
    CFG_OFF_STEP_TICKS   = 3'd1,
    CFG_STRIP_LENGTH     = 3'd2,
    CFG_FLASH_ON_MIN     = 3'd3,
    CFG_FLASH_ON_MASK    = 3'd4,
    CFG_FLASH_GAP_MIN    = 3'd5,
    CFG_FLASH_GAP_MASK   = 3'd6,
    CFG_BURST_COUNT_MASK = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [TICK_W-1:0]   rand_ticks;
    logic [RCOUNT_W-1:0] rand_count;
  } in_item_t;

  typedef struct packed {
    logic [LED_W-1:0]    lit_leds;
    logic [COLOUR_W-1:0] colour_index;
    logic                use_flash_colour;
  } out_item_t;

  typedef struct packed {
    logic [TICK_W-1:0]   on_step_ticks;
    logic [TICK_W-1:0]   off_step_ticks;
    logic [LED_W-1:0]    strip_length;
    logic [TICK_W-1:0]   flash_on_min;
    logic [TICK_W-1:0]   flash_on_mask;
    logic [TICK_W-1:0]   flash_gap_min;
    logic [TICK_W-1:0]   flash_gap_mask;
    logic [RCOUNT_W-1:0] burst_count_mask;
  } cfg_regs_t;

  localparam cfg_regs_t CFG_RESET = '{
    on_step_ticks:    16'd10,
    off_step_ticks:   16'd10,
    strip_length:     8'd64,
    flash_on_min:     16'd20,
    flash_on_mask:    16'd31,
    flash_gap_min:    16'd20,
    flash_gap_mask:   16'd31,
    burst_count_mask: 8'd3
  };

  // Minimum plus masked random bits, saturated at the field maximum.
  function automatic logic [TICK_W-1:0] sat_duration(input logic [TICK_W-1:0] minv,
                                                     input logic [TICK_W-1:0] mask,
                                                     input logic [TICK_W-1:0] rnd);
    logic [TICK_W:0] sum;
    sum = {1'b0, minv} + {1'b0, rnd & mask};
    return sum[TICK_W] ? TICK_MAX : sum[TICK_W-1:0];
  endfunction

endpackage

// ===== rtl/lfs_cfg_regs.sv =====
module lfs_cfg_regs #(
  parameter int MAX_LEDS = lfs_pkg::DEF_MAX_LEDS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lfs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lfs_pkg::CFG_DATA_W-1:0]   cfg_data,
  output lfs_pkg::cfg_regs_t               cfg,
  output logic [lfs_pkg::LED_W-1:0]        eff_len
);
  import lfs_pkg::*;

  localparam logic [LED_W-1:0] MaxLedsC = LED_W'(MAX_LEDS);

  cfg_regs_t        cfg_r;
  logic [LED_W-1:0] clamped;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ON_STEP_TICKS:    cfg_r.on_step_ticks    <= cfg_data;
        CFG_OFF_STEP_TICKS:   cfg_r.off_step_ticks   <= cfg_data;
        CFG_STRIP_LENGTH:     cfg_r.strip_length     <= cfg_data[LED_W-1:0];
        CFG_FLASH_ON_MIN:     cfg_r.flash_on_min     <= cfg_data;
        CFG_FLASH_ON_MASK:    cfg_r.flash_on_mask    <= cfg_data;
        CFG_FLASH_GAP_MIN:    cfg_r.flash_gap_min    <= cfg_data;
        CFG_FLASH_GAP_MASK:   cfg_r.flash_gap_mask   <= cfg_data;
        CFG_BURST_COUNT_MASK: cfg_r.burst_count_mask <= cfg_data[RCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // The strip length in use is clamped to the built maximum, and zero counts as one.
  assign clamped = (cfg_r.strip_length > MaxLedsC) ? MaxLedsC : cfg_r.strip_length;
  assign eff_len = (clamped == '0) ? LED_W'(1) : clamped;

endmodule

// ===== rtl/lfs_in_stage.sv =====
module lfs_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  lfs_pkg::in_item_t in_data,
  input  logic              advance,
  output logic              s1_valid,
  output lfs_pkg::in_item_t s1_data
);
  import lfs_pkg::*;

  logic     s1_valid_r;
  in_item_t s1_data_r;

  // The register takes a new transaction whenever it is empty or its contents move on.
  assign in_stall = s1_valid_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_data_r <= in_data;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_data  = s1_data_r;

endmodule

// ===== rtl/lfs_core.sv =====
module lfs_core #(
  parameter int COLOUR_COUNT = lfs_pkg::DEF_COLOUR_COUNT
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step_en,
  input  lfs_pkg::in_item_t          item,
  input  lfs_pkg::cfg_regs_t         cfg,
  input  logic [lfs_pkg::LED_W-1:0]  eff_len,
  output logic                       res_valid,
  output lfs_pkg::out_item_t         res_data
);
  import lfs_pkg::*;

  localparam int ColW1 = COLOUR_W + 1;
  localparam logic [ColW1-1:0] ColourCountC = ColW1'(COLOUR_COUNT);

  logic                turning_on_r,  turning_on_nxt;
  logic                turning_off_r, turning_off_nxt;
  logic [LED_W-1:0]    lit_count_r,   lit_count_nxt;
  logic [TICK_W-1:0]   step_timer_r,  step_timer_nxt;
  logic [COLOUR_W-1:0] colour_r,      colour_nxt;
  logic                flashing_r,    flashing_nxt;
  logic                flash_lit_r,   flash_lit_nxt;
  logic [TICK_W-1:0]   flash_timer_r, flash_timer_nxt;
  logic [BURST_W-1:0]  flashes_left_r, flashes_left_nxt;

  logic [TICK_W-1:0]   step_inc;
  logic [TICK_W-1:0]   step_limit;
  logic [LED_W-1:0]    lit_inc;
  logic [LED_W-1:0]    lit_dec;
  logic [ColW1-1:0]    colour_inc;
  logic [COLOUR_W-1:0] colour_wrap;
  logic [TICK_W-1:0]   flash_timer_dec;
  logic [BURST_W-1:0]  flashes_dec;
  logic [TICK_W-1:0]   on_dur;
  logic [TICK_W-1:0]   gap_dur;

  assign step_inc        = (step_timer_r == TICK_MAX) ? TICK_MAX : step_timer_r + 1'b1;
  assign step_limit      = turning_on_r ? cfg.on_step_ticks : cfg.off_step_ticks;
  assign lit_inc         = (lit_count_r == LED_MAX) ? LED_MAX : lit_count_r + 1'b1;
  assign lit_dec         = (lit_count_r == '0) ? '0 : lit_count_r - 1'b1;
  assign colour_inc      = {1'b0, colour_r} + ColW1'(1);
  assign colour_wrap     = (colour_inc >= ColourCountC) ? '0 : colour_inc[COLOUR_W-1:0];
  assign flash_timer_dec = (flash_timer_r == '0) ? '0 : flash_timer_r - 1'b1;
  assign flashes_dec     = (flash_lit_r && flashes_left_r != '0) ? flashes_left_r - 1'b1
                                                                  : flashes_left_r;
  assign on_dur  = sat_duration(cfg.flash_on_min, cfg.flash_on_mask, item.rand_ticks);
  assign gap_dur = sat_duration(cfg.flash_gap_min, cfg.flash_gap_mask, item.rand_ticks);

  always_comb begin
    turning_on_nxt   = turning_on_r;
    turning_off_nxt  = turning_off_r;
    lit_count_nxt    = lit_count_r;
    step_timer_nxt   = step_timer_r;
    colour_nxt       = colour_r;
    flashing_nxt     = flashing_r;
    flash_lit_nxt    = flash_lit_r;
    flash_timer_nxt  = flash_timer_r;
    flashes_left_nxt = flashes_left_r;
    res_valid        = 1'b0;
    res_data         = '{lit_leds: eff_len, colour_index: colour_r, use_flash_colour: 1'b0};

    unique case (op_t'(item.op))
      OP_TICK: begin
        if (turning_on_r || turning_off_r) begin
          if (step_inc < step_limit) begin
            step_timer_nxt = step_inc;
          end else begin
            step_timer_nxt = '0;
            res_valid      = 1'b1;
            if (turning_on_r) begin
              lit_count_nxt     = lit_inc;
              res_data.lit_leds = lit_inc;
              if (lit_inc >= eff_len) begin
                turning_on_nxt = 1'b0;
              end
            end else begin
              lit_count_nxt     = lit_dec;
              res_data.lit_leds = lit_dec;
              if (lit_dec == '0) begin
                turning_off_nxt = 1'b0;
              end
            end
          end
        end else begin
          step_timer_nxt = '0;
          if (flashing_r) begin
            flash_timer_nxt = flash_timer_dec;
            if (flash_timer_dec == '0) begin
              flashes_left_nxt = flashes_dec;
              res_valid        = 1'b1;
              if (flashes_dec == '0) begin
                flashing_nxt = 1'b0;
              end else if (flash_lit_r) begin
                flash_timer_nxt = gap_dur;
                flash_lit_nxt   = 1'b0;
              end else begin
                flash_timer_nxt           = on_dur;
                flash_lit_nxt             = 1'b1;
                res_data.use_flash_colour = 1'b1;
              end
            end
          end
        end
      end
      OP_TURN_ON: begin
        if (!turning_on_r && !turning_off_r) begin
          turning_on_nxt = 1'b1;
          lit_count_nxt  = '0;
        end
      end
      OP_TURN_OFF: begin
        if (!turning_on_r && !turning_off_r) begin
          turning_off_nxt = 1'b1;
          lit_count_nxt   = eff_len;
        end
      end
      OP_NEXT_COLOUR: begin
        colour_nxt            = colour_wrap;
        res_valid             = 1'b1;
        res_data.colour_index = colour_wrap;
      end
      OP_CLEAR: begin
        turning_on_nxt    = 1'b0;
        turning_off_nxt   = 1'b0;
        lit_count_nxt     = '0;
        step_timer_nxt    = '0;
        res_valid         = 1'b1;
        res_data.lit_leds = '0;
      end
      OP_FLASH: begin
        flashing_nxt     = 1'b1;
        flashes_left_nxt = {1'b0, item.rand_count & cfg.burst_count_mask} + BURST_W'(1);
        flash_timer_nxt  = on_dur;
        flash_lit_nxt    = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      turning_on_r   <= 1'b0;
      turning_off_r  <= 1'b0;
      lit_count_r    <= '0;
      step_timer_r   <= '0;
      colour_r       <= '0;
      flashing_r     <= 1'b0;
      flash_lit_r    <= 1'b0;
      flash_timer_r  <= '0;
      flashes_left_r <= '0;
    end else if (step_en) begin
      turning_on_r   <= turning_on_nxt;
      turning_off_r  <= turning_off_nxt;
      lit_count_r    <= lit_count_nxt;
      step_timer_r   <= step_timer_nxt;
      colour_r       <= colour_nxt;
      flashing_r     <= flashing_nxt;
      flash_lit_r    <= flash_lit_nxt;
      flash_timer_r  <= flash_timer_nxt;
      flashes_left_r <= flashes_left_nxt;
    end
  end

endmodule

// ===== rtl/lfs_out_stage.sv =====
module lfs_out_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               s1_valid,
  input  logic               res_valid,
  input  lfs_pkg::out_item_t res_data,
  output logic               advance,
  output logic               out_valid,
  input  logic               out_stall,
  output lfs_pkg::out_item_t out_data
);
  import lfs_pkg::*;

  logic      out_valid_r;
  out_item_t out_data_r;

  // The item in the input register may be processed when the result register is free.
  assign advance = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid && res_valid) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/led_strip_fill_and_flash_sequencer.sv =====
// A command transaction is held in the input register, then its redraw result in the result
// register, which drives the output; commands without a result only update state. One command
// is accepted per clock cycle, sustained, while the output does not stall.
// Reset: rst_n is synchronous and active low; it returns all configuration registers to
// their defaults and clears the sequencer state and both pipeline registers.
module led_strip_fill_and_flash_sequencer #(
  parameter int MAX_LEDS     = lfs_pkg::DEF_MAX_LEDS,
  parameter int COLOUR_COUNT = lfs_pkg::DEF_COLOUR_COUNT
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  lfs_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output lfs_pkg::out_item_t             out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lfs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lfs_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lfs_pkg::*;

  // Configuration registers; the effective strip length is derived from them in lfs_cfg_regs so that
  // the core sees a value already clamped to the built maximum.
  cfg_regs_t        cfg;
  logic [LED_W-1:0] eff_len;

  // Pipeline wiring between the input register, the sequencer core and the result register.
  logic      advance;
  logic      s1_valid;
  in_item_t  s1_data;
  logic      res_valid;
  out_item_t res_data;

  lfs_cfg_regs #(
    .MAX_LEDS (MAX_LEDS)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .eff_len   (eff_len)
  );

  // While a finished result is held on a stalled output, the input register can still take
  // one transaction; once both registers are full the input stalls until the output moves.
  lfs_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .advance  (advance),
    .s1_valid (s1_valid),
    .s1_data  (s1_data)
  );

  // The core applies one command per cycle unless the output stalls: a single pass of small
  // counter updates and compares, with state written as the command leaves the input register.
  lfs_core #(
    .COLOUR_COUNT (COLOUR_COUNT)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (s1_valid && advance),
    .item      (s1_data),
    .cfg       (cfg),
    .eff_len   (eff_len),
    .res_valid (res_valid),
    .res_data  (res_data)
  );

  lfs_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid),
    .res_valid (res_valid),
    .res_data  (res_data),
    .advance   (advance),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  // An output that is not stalled always frees the pipeline for a new input transaction.
  a_no_stall_through: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled while the output can move");

  // A result can only appear after a command sat in the input register.
  a_result_from_item: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(s1_valid))
    else $error("result appeared without a command");

  // A flash burst always redraws the full strip.
  a_flash_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.use_flash_colour |-> out_data.lit_leds == eff_len)
    else $error("flash redraw is not full length");

  // The colour index never leaves the palette.
  a_colour_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({1'b0, out_data.colour_index} < (COLOUR_W + 1)'(COLOUR_COUNT)))
    else $error("colour index outside the palette");
`endif

endmodule
